>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Map geometry, reset values, command, status and register codes, and the
// sequencer state type shared by the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Map geometry: one bit per page, 64 pages per map word.
    localparam int MAP_WORDS       = 512;
    localparam int WORD_BITS       = 64;
    localparam int BIT_IDX_W       = $clog2(WORD_BITS);
    localparam int WORD_IDX_W      = $clog2(MAP_WORDS);
    localparam int PAGE_IDX_W      = WORD_IDX_W + BIT_IDX_W;
    localparam int MAX_PAGES       = 32768;
    localparam int PAGE_BYTES_LOG2 = 12;
    localparam int ADDR_W          = 64;
    localparam int COUNT_W         = 16;

    // Register reset values.
    localparam logic [ADDR_W-1:0]  PAGE_BASE_RST      = 64'h0000_0000_8020_0000;
    localparam logic [COUNT_W-1:0] PAGES_IN_USE_RST   = 16'd32768;
    localparam logic [COUNT_W-1:0] RESERVED_PAGES_RST = 16'd257;

    // Commands.
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAGE_BASE      = 2'd0;
    localparam logic [1:0] CFG_PAGES_IN_USE   = 2'd1;
    localparam logic [1:0] CFG_RESERVED_PAGES = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NONE   = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_DOUBLE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ALLOC_ADDR,
        S_FREE_CALC,
        S_FREE_RD,
        S_FREE_CHK,
        S_RESP
    } t_state;

endpackage

>>> rtl/core/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Lowest-free-page allocation and page release over a one-bit-per-page map
// held in a single-port-write, registered-read word memory.
// ----------------------------------------------------------------------------
// Initialize writes every map word in turn. Allocate reads and checks map
// words in turn until one holds a free page, and skips the map when no page
// is free. Free reads the page's word and sets its bit unless already set;
// an out-of-range address skips the check. After reset a clearing pass marks
// every page used; no beat is accepted during it, while configuration writes
// are taken throughout.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // Command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [1:0] command, [65:2] address, rest zero
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata    // [63:0] page_address, [65:64] status,
                                     // [81:66] free_count, rest zero
);

    // Configuration registers
    logic [ADDR_W-1:0]  r_page_base;
    logic [COUNT_W-1:0] r_pages_in_use;
    logic [COUNT_W-1:0] r_reserved_pages;

    // Sequencer and datapath registers
    t_state                r_state,      n_state;
    logic [WORD_IDX_W-1:0] r_widx,       n_widx;
    logic [PAGE_IDX_W-1:0] r_idx,        n_idx;
    logic                  r_oob,        n_oob;
    logic [1:0]            r_cmd,        n_cmd;
    logic [ADDR_W-1:0]     r_addr,       n_addr;
    logic [COUNT_W-1:0]    r_free_total, n_free_total;
    logic [ADDR_W-1:0]     r_res_addr,   n_res_addr;
    t_status               r_res_status, n_res_status;
    logic                  r_m_valid,    n_m_valid;
    logic [87:0]           r_m_data,     n_m_data;

    // Map memory
    logic [WORD_BITS-1:0]  mem [MAP_WORDS];
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  mem_we;
    logic [WORD_IDX_W-1:0] mem_waddr;
    logic [WORD_IDX_W-1:0] mem_raddr;
    logic [WORD_BITS-1:0]  mem_wdata;

    // Derived values
    logic [COUNT_W-1:0]    managed;
    logic [COUNT_W-1:0]    reserved;
    logic [WORD_BITS-1:0]  lo_mask;
    logic [WORD_BITS-1:0]  hi_mask;
    logic [WORD_BITS-1:0]  low_bit;
    logic [BIT_IDX_W-1:0]  low_pos;
    logic [ADDR_W-1:0]     addr_diff;
    logic                  s_fire;

    assign s_fire = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_base      <= PAGE_BASE_RST;
            r_pages_in_use   <= PAGES_IN_USE_RST;
            r_reserved_pages <= RESERVED_PAGES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAGE_BASE:      r_page_base      <= i_cfg_wdata;
                CFG_PAGES_IN_USE:   r_pages_in_use   <= i_cfg_wdata[COUNT_W-1:0];
                CFG_RESERVED_PAGES: r_reserved_pages <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Managed count saturates to the map capacity; reservation to that count.
    assign managed  = (r_pages_in_use > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
                                                              : r_pages_in_use;
    assign reserved = (r_reserved_pages > managed) ? managed : r_reserved_pages;

    // Free-page pattern of map word r_widx for initialize.
    always_comb begin
        if (reserved[COUNT_W-1:BIT_IDX_W] < {1'b0, r_widx}) begin
            lo_mask = '1;
        end else if (reserved[COUNT_W-1:BIT_IDX_W] == {1'b0, r_widx}) begin
            lo_mask = {WORD_BITS{1'b1}} << reserved[BIT_IDX_W-1:0];
        end else begin
            lo_mask = '0;
        end
        if (managed[COUNT_W-1:BIT_IDX_W] > {1'b0, r_widx}) begin
            hi_mask = '1;
        end else if (managed[COUNT_W-1:BIT_IDX_W] == {1'b0, r_widx}) begin
            hi_mask = ~({WORD_BITS{1'b1}} << managed[BIT_IDX_W-1:0]);
        end else begin
            hi_mask = '0;
        end
    end

    // Lowest set bit of the word just read, isolated and then encoded.
    always_comb begin
        low_bit = r_rdata & (~r_rdata + WORD_BITS'(1));
        low_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_bit[i]) begin
                low_pos = low_pos | BIT_IDX_W'(i);
            end
        end
    end

    assign addr_diff = r_addr - r_page_base;

    always_comb begin
        n_state      = r_state;
        n_widx       = r_widx;
        n_idx        = r_idx;
        n_oob        = r_oob;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_free_total = r_free_total;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        mem_we       = 1'b0;
        mem_waddr    = r_widx;
        mem_raddr    = r_widx;
        mem_wdata    = '0;
        o_s_tready   = 1'b0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_widx = r_widx + 1'b1;
                if (r_widx == WORD_IDX_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready   = 1'b1;
                n_widx       = '0;
                n_res_addr   = '0;
                n_res_status = STAT_OK;
                if (i_s_tvalid) begin
                    n_cmd  = i_s_tdata[1:0];
                    n_addr = i_s_tdata[65:2];
                    case (i_s_tdata[1:0])
                        CMD_INIT:  n_state = S_INIT;
                        CMD_ALLOC: begin
                            if (r_free_total == '0) begin
                                n_res_status = STAT_NONE;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ALLOC_RD;
                            end
                        end
                        CMD_FREE:  n_state = S_FREE_CALC;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = lo_mask & hi_mask;
                n_widx    = r_widx + 1'b1;
                if (r_widx == WORD_IDX_W'(MAP_WORDS - 1)) begin
                    n_free_total = managed - reserved;
                    n_state      = S_RESP;
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (r_rdata == '0) begin
                    if (r_widx == WORD_IDX_W'(MAP_WORDS - 1)) begin
                        n_res_status = STAT_NONE;
                        n_state      = S_RESP;
                    end else begin
                        n_widx  = r_widx + 1'b1;
                        n_state = S_ALLOC_RD;
                    end
                end else if ({1'b0, r_widx, low_pos} < managed) begin
                    mem_we       = 1'b1;
                    mem_wdata    = r_rdata & ~low_bit;
                    n_free_total = r_free_total - 1'b1;
                    n_idx        = {r_widx, low_pos};
                    n_state      = S_ALLOC_ADDR;
                end else begin
                    // First free page lies past the managed count.
                    n_res_status = STAT_NONE;
                    n_state      = S_RESP;
                end
            end
            S_ALLOC_ADDR: begin
                n_res_addr = r_page_base
                           + {{(ADDR_W - PAGE_IDX_W - PAGE_BYTES_LOG2){1'b0}},
                              r_idx, {PAGE_BYTES_LOG2{1'b0}}};
                n_state    = S_RESP;
            end
            S_FREE_CALC: begin
                n_idx   = addr_diff[PAGE_BYTES_LOG2 +: PAGE_IDX_W];
                n_oob   = |addr_diff[ADDR_W-1:PAGE_BYTES_LOG2+PAGE_IDX_W];
                n_state = S_FREE_RD;
            end
            S_FREE_RD: begin
                mem_raddr = r_idx[PAGE_IDX_W-1:BIT_IDX_W];
                if (r_oob || ({1'b0, r_idx} >= managed)) begin
                    n_res_status = STAT_RANGE;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                mem_waddr = r_idx[PAGE_IDX_W-1:BIT_IDX_W];
                if (r_rdata[r_idx[BIT_IDX_W-1:0]]) begin
                    n_res_status = STAT_DOUBLE;
                end else begin
                    mem_we       = 1'b1;
                    mem_wdata    = r_rdata | (WORD_BITS'(1) << r_idx[BIT_IDX_W-1:0]);
                    n_free_total = r_free_total + 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {6'd0, r_free_total, r_res_status, r_res_addr};
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_widx       <= '0;
            r_free_total <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_widx       <= n_widx;
            r_free_total <= n_free_total;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_oob        <= n_oob;
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_m_data     <= n_m_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a beat");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= COUNT_W'(MAX_PAGES))
        else $error("free page count exceeds map capacity");

    a_none_has_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_data[65:64] != STAT_OK)) |-> (r_m_data[63:0] == '0))
        else $error("failed command returned a page address");

    a_alloc_only_ok_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_ADDR) |-> (r_cmd == CMD_ALLOC))
        else $error("address stage reached by a command other than allocate");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives initialize, allocate, free and unknown commands through the command
// stream and checks every result beat against a page map kept in step with
// the block. Register settings change between phases, including the
// extremes. Beats are sent in bursts with random gaps while the result side
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench
    import bpa_pkg::*;
();

    localparam logic [1:0] CMD_UNKNOWN    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_ITEMS    = 100;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         MAX_REPORTS    = 50;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] address;
    } t_cmd_beat;

    typedef struct {
        logic [63:0] page_addr;
        t_status     status;
        logic [15:0] free_count;
    } t_alloc_result;

    typedef enum {RX_STEADY, RX_HALF, RX_SPARSE} t_rx_mode;

    class page_map_scoreboard;
        logic [63:0]   map_words [MAP_WORDS];
        int            free_left;
        logic [63:0]   base_reg;
        logic [15:0]   pages_reg;
        logic [15:0]   reserved_reg;
        t_alloc_result awaited_results [$];
        int            errors;
        int            result_count;

        function new();
            base_reg     = PAGE_BASE_RST;
            pages_reg    = PAGES_IN_USE_RST;
            reserved_reg = RESERVED_PAGES_RST;
            foreach (map_words[i]) map_words[i] = '0;
            free_left    = 0;
            errors       = 0;
            result_count = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [63:0] value);
            case (idx)
                CFG_PAGE_BASE:      base_reg = value;
                CFG_PAGES_IN_USE:   pages_reg = value[15:0];
                CFG_RESERVED_PAGES: reserved_reg = value[15:0];
                default: ;
            endcase
        endfunction

        function int managed_count();
            int n;
            n = pages_reg;
            if (n > MAX_PAGES) n = MAX_PAGES;
            if (n > MAP_WORDS * WORD_BITS) n = MAP_WORDS * WORD_BITS;
            return n;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_command(logic [1:0] cmd, logic [63:0] addr);
            t_alloc_result res;
            int            n;
            int            lim;
            int            w;
            int            b;
            int            idx;
            bit            found;
            logic [63:0]   page_off;
            n = managed_count();
            res.page_addr = '0;
            res.status    = STAT_OK;
            found         = 1'b0;
            case (cmd)
                CMD_INIT: begin
                    lim = (reserved_reg > n) ? n : reserved_reg;
                    foreach (map_words[i]) map_words[i] = '0;
                    for (idx = lim; idx < n; idx++)
                        map_words[WORD_IDX_W'(idx / WORD_BITS)]
                                 [BIT_IDX_W'(idx % WORD_BITS)] = 1'b1;
                    free_left = n - lim;
                end
                CMD_ALLOC: begin
                    res.status = STAT_NONE;
                    if (free_left != 0) begin
                        // Only the first word holding a free bit is looked at; a free
                        // page past the managed count there still ends the search.
                        for (w = 0; w < MAP_WORDS && !found; w++) begin
                            if (map_words[WORD_IDX_W'(w)] != '0) begin
                                found = 1'b1;
                                b = 0;
                                while (!map_words[WORD_IDX_W'(w)][BIT_IDX_W'(b)]) b++;
                                idx = w * WORD_BITS + b;
                                if (idx < n) begin
                                    map_words[WORD_IDX_W'(w)][BIT_IDX_W'(b)] = 1'b0;
                                    free_left--;
                                    res.page_addr = base_reg + (64'(idx) << PAGE_BYTES_LOG2);
                                    res.status    = STAT_OK;
                                end
                            end
                        end
                    end
                end
                CMD_FREE: begin
                    page_off = (addr - base_reg) >> PAGE_BYTES_LOG2;
                    if (page_off >= 64'(n)) begin
                        res.status = STAT_RANGE;
                    end else if (map_words[WORD_IDX_W'(page_off / WORD_BITS)]
                                          [BIT_IDX_W'(page_off % WORD_BITS)]) begin
                        res.status = STAT_DOUBLE;
                    end else begin
                        map_words[WORD_IDX_W'(page_off / WORD_BITS)]
                                 [BIT_IDX_W'(page_off % WORD_BITS)] = 1'b1;
                        free_left++;
                    end
                end
                default: ;
            endcase
            res.free_count = 16'(free_left);
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("result %0d: %s is %h, expected %h", result_count, what, got, want);
        endtask

        task check_result(logic [87:0] beat);
            t_alloc_result want;
            result_count++;
            if (awaited_results.size() == 0) begin
                report_mismatch("page_address of a beat with nothing outstanding",
                                beat[63:0], '0);
                return;
            end
            want = awaited_results.pop_front();
            if (beat[63:0] !== want.page_addr)
                report_mismatch("page_address", beat[63:0], want.page_addr);
            if (t_status'(beat[65:64]) !== want.status)
                report_mismatch("status", 64'(beat[65:64]), 64'(want.status));
            if (beat[81:66] !== want.free_count)
                report_mismatch("free_count", 64'(beat[81:66]), 64'(want.free_count));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [71:0] cmd_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [87:0] res_data;

    page_map_scoreboard sb;
    t_cmd_beat          command_queue [$];
    bit                 rx_hold_req = 1'b0;
    int                 idle_cycles = 0;

    bitmap_page_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (cmd_valid),
        .o_s_tready  (cmd_ready),
        .i_s_tdata   (cmd_data),   // [1:0] command, [65:2] address, rest zero
        .o_m_tvalid  (res_valid),
        .i_m_tready  (res_ready),
        .o_m_tdata   (res_data)    // [63:0] page_address, [65:64] status,
                                   // [81:66] free_count, rest zero
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready) sb.note_command(cmd_data[1:0], cmd_data[65:2]);
            if (res_valid && res_ready) sb.check_result(res_data);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: runs of steady, half-rate and sparse readiness, and one long
    // hold-off when asked for, so the allocator backs up into its input.
    initial begin
        t_rx_mode mode;
        int       run_len;
        forever begin
            if (rx_hold_req) begin
                @(negedge clk) res_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end else begin
                mode    = t_rx_mode'($urandom_range(0, 2));
                run_len = $urandom_range(16, 200);
                while (run_len != 0 && !rx_hold_req) begin
                    @(negedge clk);
                    case (mode)
                        RX_STEADY: res_ready <= 1'b1;
                        RX_HALF:   res_ready <= 1'($urandom_range(0, 1));
                        default:   res_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    run_len--;
                end
            end
        end
    end

    function automatic void queue_command(logic [1:0] cmd, logic [63:0] addr);
        command_queue.push_back('{command: cmd, address: addr});
    endfunction

    task automatic send_beat(t_cmd_beat beat);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data  <= {6'b0, beat.address, beat.command};
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk) cmd_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic play_commands();
        int burst;
        while (command_queue.size() != 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst != 0 && command_queue.size() != 0) begin
                send_beat(command_queue.pop_front());
                burst--;
            end
            pause_sender($urandom_range(1, 10));
        end
    endtask

    // Every command answers with exactly one beat, so an empty store means idle.
    task automatic wait_results();
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk) cfg_we <= 1'b0;
        sb.write_register(idx, value);
    endtask

    // With junk set, the bits above the 16-bit count registers carry noise.
    task automatic set_config(logic [63:0] base, int pages, int reserved, bit junk);
        logic [63:0] upper;
        upper = junk ? {$urandom, $urandom} : '0;
        write_register(CFG_PAGE_BASE, base);
        write_register(CFG_PAGES_IN_USE, {upper[63:16], 16'(pages)});
        write_register(CFG_RESERVED_PAGES, {upper[63:16], 16'(reserved)});
    endtask

    task automatic run_directed();
        logic [63:0] wrap_base;
        wrap_base = 64'hFFFF_FFFF_FFFF_E000;
        // Straight out of reset every page is marked used.
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_FREE, PAGE_BASE_RST);
        queue_command(CMD_ALLOC, '1);
        queue_command(CMD_INIT, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_FREE, PAGE_BASE_RST + 64'hFFF);
        queue_command(CMD_UNKNOWN, '1);
        play_commands();
        wait_results();

        // Three pages just below the top of the address space: the last one wraps
        // to address zero, then exhaustion, double free and both range edges.
        set_config(wrap_base, 3, 1, 1'b0);
        queue_command(CMD_INIT, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_FREE, 64'hFFF);
        queue_command(CMD_FREE, 64'h0);
        queue_command(CMD_FREE, 64'h1000);
        queue_command(CMD_FREE, wrap_base - 64'd1);
        play_commands();
        wait_results();

        // Shrinking the count leaves the free page above it out of reach.
        write_register(CFG_PAGES_IN_USE, 64'd2);
        queue_command(CMD_ALLOC, 64'h0);
        play_commands();
        wait_results();

        set_config(wrap_base, 0, 0, 1'b1);
        queue_command(CMD_FREE, wrap_base);
        queue_command(CMD_INIT, 64'h0);
        play_commands();
        wait_results();

        // Count saturates at the map size and the whole of it is reserved.
        set_config(64'h0, 65535, 65535, 1'b1);
        queue_command(CMD_INIT, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_FREE, '1);
        play_commands();
        wait_results();

        // Only the very last page is free, so the search walks the whole map.
        write_register(CFG_RESERVED_PAGES, 64'd32767);
        queue_command(CMD_INIT, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        queue_command(CMD_FREE, 64'h7FF_FFFF);
        play_commands();
        wait_results();

        set_config(64'h0, 1, 0, 1'b0);
        queue_command(CMD_INIT, 64'h0);
        queue_command(CMD_ALLOC, 64'h0);
        play_commands();
        wait_results();
    endtask

    task automatic run_random();
        logic [63:0] base;
        int          pages;
        int          reserved;
        int          n;
        int          idx;
        int          pick;
        int          split;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            base = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: ;
                1: base[PAGE_BYTES_LOG2-1:0] = '0;
                2: base = '1 - (64'($urandom_range(0, 64)) << PAGE_BYTES_LOG2);
                default: base = PAGE_BASE_RST;
            endcase
            if (phase % 4 == 0) begin
                pages    = $urandom_range(0, 1) ? MAX_PAGES : $urandom_range(1000, 65535);
                reserved = $urandom_range(0, 400);
            end else begin
                pages    = $urandom_range(1, 300);
                reserved = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                       : $urandom_range(0, pages / 2);
            end
            set_config(base, pages, reserved, 1'($urandom_range(0, 1)));
            // Now and then the map is carried over from the previous phase.
            if (phase == 0 || $urandom_range(0, 3) != 0) queue_command(CMD_INIT, 64'h0);
            split = (phase % 3 == 1) ? PHASE_ITEMS / 2 : PHASE_ITEMS;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == split) begin
                    play_commands();
                    wait_results();
                    pages = $urandom_range(1, pages + 64);
                    write_register(CFG_PAGES_IN_USE, 64'(pages));
                end
                n    = (pages > MAX_PAGES) ? MAX_PAGES : pages;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    queue_command(CMD_ALLOC, {$urandom, $urandom});
                end else if (pick < 85) begin
                    idx = $urandom_range(0, ((n < 320) ? n : 320) + 3);
                    queue_command(CMD_FREE, base + (64'(idx) << PAGE_BYTES_LOG2)
                                            + 64'($urandom_range(0, 4095)));
                end else if (pick < 91) begin
                    queue_command(CMD_FREE, {$urandom, $urandom});
                end else if (pick < 96) begin
                    queue_command(CMD_UNKNOWN, {$urandom, $urandom});
                end else begin
                    queue_command(CMD_INIT, {$urandom, $urandom});
                end
            end
            if (phase == 2) rx_hold_req = 1'b1;
            play_commands();
            wait_results();
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        run_directed();
        run_random();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> bitmap_page_allocator.f
rtl/core/bpa_pkg.sv
rtl/core/bitmap_page_allocator.sv
tb/sv/testbench.sv
